@@ src/tile_fetch_scheduler_macros.svh @@
// ---------------------------------------------------------------------------
// tile fetch scheduler assertion macros
// shared property shapes for the port checker
// ---------------------------------------------------------------------------
`ifndef TILE_FETCH_SCHEDULER_MACROS_SVH
`define TILE_FETCH_SCHEDULER_MACROS_SVH

// same-cycle implication, held off during reset
`define TFS_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tile_fetch_scheduler: same-cycle check failed");

// next-cycle implication, held off during reset
`define TFS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tile_fetch_scheduler: next-cycle check failed");

`endif

@@ src/tfs_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tfs_pkg
// shared types and field widths of the tile fetch scheduler
// ---------------------------------------------------------------------------
package tfs_pkg;

    localparam int COORD_W = 18;
    localparam int ZOOM_W  = 5;
    localparam int WID_W   = 2;
    localparam int COUNT_W = 7;

    // one pending tile
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [ZOOM_W-1:0]  zoom;
    } entry_t;

    // state update and result chosen for one request
    typedef enum logic [2:0] {
        OP_NONE,
        OP_ASSIGN,
        OP_ENQUEUE,
        OP_DROP,
        OP_RELEASE,
        OP_IGNORE,
        OP_REMOVE
    } op_t;

    typedef struct packed {
        logic latch;
        op_t  op;
        logic scan_start;
        logic shift_start;
    } cmd_t;

    typedef struct packed {
        logic kind;
        logic any_free;
        logic queue_full;
        logic queue_empty;
        logic wid_busy;
        logic scan_done;
        logic shift_done;
    } status_t;

endpackage

@@ src/tfs_ctrl.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tfs_ctrl
// sequencer: takes a request, picks the action and drives the handshakes
// ---------------------------------------------------------------------------
module tfs_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    output logic            m_valid,
    input  logic            m_ready,
    input  tfs_pkg::status_t st,
    output tfs_pkg::cmd_t   cmd
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_DECIDE = 5'b00010,
        ST_SCAN   = 5'b00100,
        ST_SHIFT  = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    // result slot can take a new result this cycle
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign s_ready  = (state_reg == ST_IDLE);

    // next state and commands
    always_comb begin
        state_next      = state_reg;
        cmd.latch       = 1'b0;
        cmd.op          = tfs_pkg::OP_NONE;
        cmd.scan_start  = 1'b0;
        cmd.shift_start = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.latch  = 1'b1;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (!st.kind) begin
                    if (out_free) begin
                        if (st.any_free) begin
                            cmd.op = tfs_pkg::OP_ASSIGN;
                        end else if (st.queue_full) begin
                            cmd.op = tfs_pkg::OP_DROP;
                        end else begin
                            cmd.op = tfs_pkg::OP_ENQUEUE;
                        end
                        state_next = ST_IDLE;
                    end
                end else if (!st.wid_busy) begin
                    if (out_free) begin
                        cmd.op     = tfs_pkg::OP_IGNORE;
                        state_next = ST_IDLE;
                    end
                end else if (st.queue_empty) begin
                    if (out_free) begin
                        cmd.op     = tfs_pkg::OP_RELEASE;
                        state_next = ST_IDLE;
                    end
                end else begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (st.scan_done) begin
                    cmd.shift_start = 1'b1;
                    state_next      = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                if (st.shift_done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    cmd.op     = tfs_pkg::OP_REMOVE;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result valid holds until taken
    assign m_valid_next = (cmd.op != tfs_pkg::OP_NONE) || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

@@ src/tfs_datapath.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tfs_datapath
// worker busy bits, pending queue memory, priority scan and queue compaction
// ---------------------------------------------------------------------------
module tfs_datapath #(
    parameter int WORKERS     = 4,
    parameter int QUEUE_DEPTH = 64,
    parameter int MAX_ZOOM    = 18
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  tfs_pkg::cmd_t                      cmd,
    output tfs_pkg::status_t                   st,
    input  logic                               s_kind,
    input  logic [tfs_pkg::COORD_W-1:0]        s_tile_x,
    input  logic [tfs_pkg::COORD_W-1:0]        s_tile_y,
    input  logic [tfs_pkg::ZOOM_W-1:0]         s_tile_zoom,
    input  logic [tfs_pkg::WID_W-1:0]          s_worker_id,
    input  logic [tfs_pkg::COORD_W-1:0]        s_center_x,
    input  logic [tfs_pkg::COORD_W-1:0]        s_center_y,
    input  logic [tfs_pkg::ZOOM_W-1:0]         s_view_zoom,
    output logic                               m_dispatch_valid,
    output logic [tfs_pkg::WID_W-1:0]          m_dispatch_worker,
    output logic [tfs_pkg::COORD_W-1:0]        m_dispatch_x,
    output logic [tfs_pkg::COORD_W-1:0]        m_dispatch_y,
    output logic [tfs_pkg::ZOOM_W-1:0]         m_dispatch_zoom,
    output logic                               m_queued,
    output logic                               m_dropped,
    output logic [tfs_pkg::COUNT_W-1:0]        m_pending_count
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int WW = (WORKERS > 1) ? $clog2(WORKERS) : 1;
    localparam int SQ_W   = 2 * tfs_pkg::COORD_W;
    localparam int DIST_W = SQ_W + 1;
    localparam logic [tfs_pkg::ZOOM_W-1:0] ZMAX  = tfs_pkg::ZOOM_W'(MAX_ZOOM);
    localparam logic [tfs_pkg::ZOOM_W-1:0] ZMIN  = tfs_pkg::ZOOM_W'(1);
    localparam logic [CW-1:0]              QFULL = CW'(QUEUE_DEPTH);

    // latched request
    logic                        kind_reg;
    tfs_pkg::entry_t             req_reg;
    logic [tfs_pkg::WID_W-1:0]   wid_reg;
    logic [tfs_pkg::COORD_W-1:0] cx_reg, cy_reg;
    logic [tfs_pkg::ZOOM_W-1:0]  vz_reg, vz_clamped;

    // control state
    logic [WORKERS-1:0] busy_reg, busy_next;
    logic [CW-1:0]      total_reg, total_next;

    // queue memory
    logic [$bits(tfs_pkg::entry_t)-1:0] mem [QUEUE_DEPTH];
    logic                               wr_en;
    logic [AW-1:0]                      wr_addr, rd_addr;
    tfs_pkg::entry_t                    wr_data, rd_data_reg;

    // scan pipeline
    logic                        scan_active_reg;
    logic [CW-1:0]               scan_cnt_reg;
    logic                        p1_valid_reg, p2_valid_reg;
    logic [AW-1:0]               p1_idx_reg, p2_idx_reg;
    tfs_pkg::entry_t             p2_entry_reg;
    logic [SQ_W-1:0]             p2_sqx_reg, p2_sqy_reg;
    logic [tfs_pkg::ZOOM_W-1:0]  p2_gap_reg;
    logic [tfs_pkg::COORD_W-1:0] dx, dy;
    logic [SQ_W-1:0]             sqx, sqy;
    logic [tfs_pkg::ZOOM_W-1:0]  gap;
    logic [DIST_W-1:0]           cand_dist;
    logic                        better;

    // best candidate
    tfs_pkg::entry_t             best_entry_reg;
    logic [DIST_W-1:0]           best_dist_reg;
    logic [tfs_pkg::ZOOM_W-1:0]  best_gap_reg;
    logic [AW-1:0]               best_idx_reg;

    // compaction
    logic          sh_active_reg;
    logic [CW-1:0] sh_rd_reg;
    logic          sh_wr_valid_reg;
    logic [AW-1:0] sh_wr_addr_reg;

    // worker selection
    logic [WW-1:0]      free_idx;
    logic [WORKERS-1:0] free_mask, wid_mask;

    // result
    logic                        res_dv, res_q, res_dr;
    logic [tfs_pkg::WID_W-1:0]   res_dw;
    tfs_pkg::entry_t             res_entry;

    // view zoom clamp at capture
    always_comb begin
        vz_clamped = s_view_zoom;
        if (s_view_zoom < ZMIN) begin
            vz_clamped = ZMIN;
        end else if (s_view_zoom > ZMAX) begin
            vz_clamped = ZMAX;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            kind_reg     <= s_kind;
            req_reg.x    <= s_tile_x;
            req_reg.y    <= s_tile_y;
            req_reg.zoom <= s_tile_zoom;
            wid_reg      <= s_worker_id;
            cx_reg       <= s_center_x;
            cy_reg       <= s_center_y;
            vz_reg       <= vz_clamped;
        end
    end

    // lowest idle worker
    always_comb begin
        free_idx = '0;
        for (int i = WORKERS - 1; i >= 0; i--) begin
            if (!busy_reg[i]) begin
                free_idx = WW'(i);
            end
        end
    end

    assign free_mask = WORKERS'(1) << free_idx;
    // out-of-range ids shift out and match nothing
    assign wid_mask  = WORKERS'(1) << wid_reg;

    // status to the sequencer
    assign st.kind        = kind_reg;
    assign st.any_free    = !(&busy_reg);
    assign st.queue_full  = (total_reg == QFULL);
    assign st.queue_empty = (total_reg == '0);
    assign st.wid_busy    = |(busy_reg & wid_mask);
    assign st.scan_done   = !scan_active_reg && !p1_valid_reg && !p2_valid_reg;
    assign st.shift_done  = !sh_active_reg && !sh_wr_valid_reg;

    // busy bits, count and result per action
    always_comb begin
        busy_next  = busy_reg;
        total_next = total_reg;
        res_dv     = 1'b0;
        res_dw     = '0;
        res_entry  = '0;
        res_q      = 1'b0;
        res_dr     = 1'b0;
        case (cmd.op)
            tfs_pkg::OP_ASSIGN: begin
                busy_next = busy_reg | free_mask;
                res_dv    = 1'b1;
                res_dw    = tfs_pkg::WID_W'(free_idx);
                res_entry = req_reg;
            end
            tfs_pkg::OP_ENQUEUE: begin
                total_next = total_reg + CW'(1);
                res_q      = 1'b1;
            end
            tfs_pkg::OP_DROP: begin
                res_dr = 1'b1;
            end
            tfs_pkg::OP_RELEASE: begin
                busy_next = busy_reg & ~wid_mask;
            end
            tfs_pkg::OP_REMOVE: begin
                total_next = total_reg - CW'(1);
                res_dv     = 1'b1;
                res_dw     = wid_reg;
                res_entry  = best_entry_reg;
            end
            default: begin
            end
        endcase
    end

    // memory port selection
    assign wr_en   = (cmd.op == tfs_pkg::OP_ENQUEUE) || sh_wr_valid_reg;
    assign wr_addr = sh_wr_valid_reg ? sh_wr_addr_reg : total_reg[AW-1:0];
    assign wr_data = sh_wr_valid_reg ? rd_data_reg : req_reg;
    assign rd_addr = scan_active_reg ? scan_cnt_reg[AW-1:0] : sh_rd_reg[AW-1:0];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // scan stage 1: distance terms of the entry just read
    assign dx  = (rd_data_reg.x >= cx_reg) ? rd_data_reg.x - cx_reg : cx_reg - rd_data_reg.x;
    assign dy  = (rd_data_reg.y >= cy_reg) ? rd_data_reg.y - cy_reg : cy_reg - rd_data_reg.y;
    assign sqx = SQ_W'(dx) * SQ_W'(dx);
    assign sqy = SQ_W'(dy) * SQ_W'(dy);
    assign gap = (rd_data_reg.zoom >= vz_reg) ? rd_data_reg.zoom - vz_reg
                                              : vz_reg - rd_data_reg.zoom;

    always_ff @(posedge aclk) begin
        if (p1_valid_reg) begin
            p2_idx_reg   <= p1_idx_reg;
            p2_entry_reg <= rd_data_reg;
            p2_sqx_reg   <= sqx;
            p2_sqy_reg   <= sqy;
            p2_gap_reg   <= gap;
        end
    end

    // scan stage 2: compare against the running best
    assign cand_dist = DIST_W'(p2_sqx_reg) + DIST_W'(p2_sqy_reg);
    assign better    = (p2_entry_reg.zoom == best_entry_reg.zoom) ? (cand_dist < best_dist_reg)
                                                                  : (p2_gap_reg < best_gap_reg);

    always_ff @(posedge aclk) begin
        if (p2_valid_reg && ((p2_idx_reg == '0) || better)) begin
            best_entry_reg <= p2_entry_reg;
            best_dist_reg  <= cand_dist;
            best_gap_reg   <= p2_gap_reg;
            best_idx_reg   <= p2_idx_reg;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (cmd.op != tfs_pkg::OP_NONE) begin
            m_dispatch_valid  <= res_dv;
            m_dispatch_worker <= res_dw;
            m_dispatch_x      <= res_entry.x;
            m_dispatch_y      <= res_entry.y;
            m_dispatch_zoom   <= res_entry.zoom;
            m_queued          <= res_q;
            m_dropped         <= res_dr;
            m_pending_count   <= tfs_pkg::COUNT_W'(total_next);
        end
    end

    // control registers: busy bits, count, scan issue and compaction sweep
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg        <= '0;
            total_reg       <= '0;
            scan_active_reg <= 1'b0;
            scan_cnt_reg    <= '0;
            p1_valid_reg    <= 1'b0;
            p1_idx_reg      <= '0;
            p2_valid_reg    <= 1'b0;
            sh_active_reg   <= 1'b0;
            sh_rd_reg       <= '0;
            sh_wr_valid_reg <= 1'b0;
            sh_wr_addr_reg  <= '0;
        end else begin
            busy_reg  <= busy_next;
            total_reg <= total_next;

            // one entry read per cycle, oldest first
            p1_valid_reg <= scan_active_reg;
            p1_idx_reg   <= scan_cnt_reg[AW-1:0];
            p2_valid_reg <= p1_valid_reg;
            if (cmd.scan_start) begin
                scan_active_reg <= 1'b1;
                scan_cnt_reg    <= '0;
            end else if (scan_active_reg) begin
                scan_cnt_reg <= scan_cnt_reg + CW'(1);
                if (scan_cnt_reg + CW'(1) == total_reg) begin
                    scan_active_reg <= 1'b0;
                end
            end

            // move every entry after the best one down by one
            sh_wr_valid_reg <= sh_active_reg;
            sh_wr_addr_reg  <= AW'(sh_rd_reg - CW'(1));
            if (cmd.shift_start) begin
                sh_rd_reg     <= CW'(best_idx_reg) + CW'(1);
                sh_active_reg <= (CW'(best_idx_reg) + CW'(1) < total_reg);
            end else if (sh_active_reg) begin
                sh_rd_reg <= sh_rd_reg + CW'(1);
                if (!(sh_rd_reg + CW'(1) < total_reg)) begin
                    sh_active_reg <= 1'b0;
                end
            end
        end
    end

endmodule

@@ src/tile_fetch_scheduler.sv @@
`timescale 1ns / 1ps
// new request, release or ignored completion: decided in the decide state, result registered once the slot is free
// a completion with pending entries: a priority scan of the queue, then compaction of the entries
// after the best one (none when the best is the last entry), then the result is registered
// one request in work at a time; a waiting result stalls
// reset clears the worker busy bits, the pending count and all control; queue memory
// keeps its contents and needs no clearing pass
// ---------------------------------------------------------------------------
// tile_fetch_scheduler
// hands tile requests to a pool of workers with a priority-scanned pending queue
// ---------------------------------------------------------------------------
module tile_fetch_scheduler #(
    parameter int WORKERS     = 4,
    parameter int QUEUE_DEPTH = 64,
    parameter int MAX_ZOOM    = 18
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_kind,
    input  logic [tfs_pkg::COORD_W-1:0] s_tile_x,
    input  logic [tfs_pkg::COORD_W-1:0] s_tile_y,
    input  logic [tfs_pkg::ZOOM_W-1:0]  s_tile_zoom,
    input  logic [tfs_pkg::WID_W-1:0]   s_worker_id,
    input  logic [tfs_pkg::COORD_W-1:0] s_center_x,
    input  logic [tfs_pkg::COORD_W-1:0] s_center_y,
    input  logic [tfs_pkg::ZOOM_W-1:0]  s_view_zoom,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_dispatch_valid,
    output logic [tfs_pkg::WID_W-1:0]   m_dispatch_worker,
    output logic [tfs_pkg::COORD_W-1:0] m_dispatch_x,
    output logic [tfs_pkg::COORD_W-1:0] m_dispatch_y,
    output logic [tfs_pkg::ZOOM_W-1:0]  m_dispatch_zoom,
    output logic                        m_queued,
    output logic                        m_dropped,
    output logic [tfs_pkg::COUNT_W-1:0] m_pending_count
);

    tfs_pkg::cmd_t    cmd;
    tfs_pkg::status_t st;

    // sequencer
    tfs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .st      (st),
        .cmd     (cmd)
    );

    // queue, workers and scan datapath
    tfs_datapath #(
        .WORKERS     (WORKERS),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .MAX_ZOOM    (MAX_ZOOM)
    ) u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .st                (st),
        .s_kind            (s_kind),
        .s_tile_x          (s_tile_x),
        .s_tile_y          (s_tile_y),
        .s_tile_zoom       (s_tile_zoom),
        .s_worker_id       (s_worker_id),
        .s_center_x        (s_center_x),
        .s_center_y        (s_center_y),
        .s_view_zoom       (s_view_zoom),
        .m_dispatch_valid  (m_dispatch_valid),
        .m_dispatch_worker (m_dispatch_worker),
        .m_dispatch_x      (m_dispatch_x),
        .m_dispatch_y      (m_dispatch_y),
        .m_dispatch_zoom   (m_dispatch_zoom),
        .m_queued          (m_queued),
        .m_dropped         (m_dropped),
        .m_pending_count   (m_pending_count)
    );

endmodule

@@ src/tfs_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tfs_checker
// port-level checks of the tile fetch scheduler, bound to the top level
// ---------------------------------------------------------------------------
`include "tile_fetch_scheduler_macros.svh"

module tfs_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic                        m_dispatch_valid,
    input logic [tfs_pkg::WID_W-1:0]   m_dispatch_worker,
    input logic [tfs_pkg::COORD_W-1:0] m_dispatch_x,
    input logic [tfs_pkg::ZOOM_W-1:0]  m_dispatch_zoom,
    input logic                        m_queued,
    input logic                        m_dropped,
    input logic [tfs_pkg::COUNT_W-1:0] m_pending_count
);

    // one request at a time: no new request right after one is taken
    `TFS_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_valid && s_ready, !s_ready)

    // a stalled result holds
    `TFS_ASSERT_NEXT(a_result_holds, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_dispatch_x) && $stable(m_pending_count))

    // a request is dispatched, queued or dropped, never two of these
    `TFS_ASSERT_IMPLY(a_flags_exclusive, aclk, aresetn, m_valid, !(m_queued && m_dropped) && !(m_dispatch_valid && (m_queued || m_dropped)))

    // no dispatch shows zero tile fields
    `TFS_ASSERT_IMPLY(a_idle_fields_zero, aclk, aresetn, m_valid && !m_dispatch_valid, m_dispatch_x == '0 && m_dispatch_zoom == '0 && m_dispatch_worker == '0)

endmodule

bind tile_fetch_scheduler tfs_checker u_tfs_checker (.*);
